>>> rtl/core/cqf_pkg.sv
// shared types, constants and index helpers for the circular queue fifo
// no dependencies; cqf_front, cqf_back and the top level refer to it by scoped names
package cqf_pkg;

    localparam int MAX_SLOTS = 16;
    localparam int IDX_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int LEN_W     = $clog2(MAX_SLOTS + 1);
    localparam int SIZE_W    = 5;
    localparam int WORD_W    = 32;
    localparam int FUNC_W    = 2;
    localparam int STATUS_W  = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH = 2'd0,
        FUNC_POP  = 2'd1,
        FUNC_SHOW = 2'd2
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        OP_PUSH,
        OP_POP,
        OP_SHOW
    } op_t;

    typedef struct packed {
        op_t                      op;
        logic signed [WORD_W-1:0] word;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_POP_WAIT,
        BK_SHOW
    } bk_state_t;

    // slot count in use, size clamped to 2 .. MAX_SLOTS
    function automatic logic [LEN_W-1:0] ring_len(input logic [SIZE_W-1:0] size);
        logic [LEN_W-1:0] len;
        if (int'(size) < 2)
            len = LEN_W'(2);
        else if (int'(size) > MAX_SLOTS)
            len = LEN_W'(MAX_SLOTS);
        else
            len = LEN_W'(size);
        return len;
    endfunction

    // index advance with wrap at the ring length
    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx,
                                                  input logic [LEN_W-1:0] len);
        logic [IDX_W-1:0] nxt;
        if (int'(idx) + 1 >= int'(len))
            nxt = '0;
        else
            nxt = idx + IDX_W'(1);
        return nxt;
    endfunction

endpackage

>>> rtl/core/cqf_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
module cqf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic [$clog2(DEPTH)-1:0]         wr_addr,
    input  logic [WIDTH-1:0]                 wr_data,
    input  logic                             rd_en,
    input  logic [$clog2(DEPTH)-1:0]         rd_addr,
    output logic [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/cqf_front.sv
// front end: accepts items, classifies the operation, queues commands
// depends on cqf_pkg
module cqf_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [cqf_pkg::FUNC_W-1:0]        func,
    input  logic signed [cqf_pkg::WORD_W-1:0] push_value,
    output logic                              cmd_valid,
    output cqf_pkg::cmd_t                     cmd,
    input  logic                              cmd_take
);

    cqf_pkg::cmd_t entry_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;
    logic          accept;
    logic          enq;
    logic          deq;
    cqf_pkg::cmd_t new_cmd;
    logic          known_op;

    // classify, unused code is dropped here
    always_comb
    begin
        new_cmd.word = push_value;
        known_op     = 1'b1;
        case (func)
            cqf_pkg::FUNC_PUSH: new_cmd.op = cqf_pkg::OP_PUSH;
            cqf_pkg::FUNC_POP:  new_cmd.op = cqf_pkg::OP_POP;
            cqf_pkg::FUNC_SHOW: new_cmd.op = cqf_pkg::OP_SHOW;
            default:
            begin
                new_cmd.op = cqf_pkg::OP_PUSH;
                known_op   = 1'b0;
            end
        endcase
    end

    assign in_stall  = (count_reg == 2'd2);
    assign accept    = in_valid && !in_stall;
    assign enq       = accept && known_op;
    assign cmd_valid = (count_reg != 2'd0);
    assign deq       = cmd_valid && cmd_take;
    assign cmd       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (enq && !deq)
            count_next = count_reg + 2'd1;
        else if (deq && !enq)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (enq)
                wr_ptr_reg <= !wr_ptr_reg;
            if (deq)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            entry_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

>>> rtl/core/cqf_back.sv
// back end: ring indices, slot ram, show walk sequencer and result register
// depends on cqf_pkg and cqf_ram
module cqf_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cmd_valid,
    input  cqf_pkg::cmd_t                      cmd,
    output logic                               cmd_take,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [cqf_pkg::SIZE_W-1:0]         queue_size,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [cqf_pkg::STATUS_W-1:0]       status,
    output logic signed [cqf_pkg::WORD_W-1:0]  value,
    output logic                               is_last,
    output logic                               now_empty,
    output logic                               now_full
);

    cqf_pkg::bk_state_t              state_reg, state_next;
    logic [cqf_pkg::SIZE_W-1:0]      size_reg, size_next;
    logic [cqf_pkg::IDX_W-1:0]       head_reg, head_next;
    logic [cqf_pkg::IDX_W-1:0]       tail_reg, tail_next;
    logic [cqf_pkg::IDX_W-1:0]       walk_reg, walk_next;
    logic [cqf_pkg::LEN_W-1:0]       len;
    logic [cqf_pkg::IDX_W-1:0]       head_adv, tail_adv, walk_adv;
    logic                            empty_now, full_now, walk_done;
    logic                            out_free, cfg_fire;

    logic                            out_valid_reg, out_valid_next;
    cqf_pkg::status_t                status_reg;
    logic signed [cqf_pkg::WORD_W-1:0] value_reg;
    logic                            is_last_reg, now_empty_reg, now_full_reg;

    logic                            load;
    cqf_pkg::status_t                ld_status;
    logic signed [cqf_pkg::WORD_W-1:0] ld_value;
    logic                            ld_last;
    logic                            empty_after, full_after;

    logic                            wr_en, rd_en;
    logic [cqf_pkg::IDX_W-1:0]       wr_addr, rd_addr;
    logic [cqf_pkg::WORD_W-1:0]      rd_data;

    cqf_ram #(
        .WIDTH (cqf_pkg::WORD_W),
        .DEPTH (cqf_pkg::MAX_SLOTS)
    ) u_slots (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (cmd.word),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign len       = cqf_pkg::ring_len(size_reg);
    assign head_adv  = cqf_pkg::next_idx(head_reg, len);
    assign tail_adv  = cqf_pkg::next_idx(tail_reg, len);
    assign walk_adv  = cqf_pkg::next_idx(walk_reg, len);
    assign empty_now = (head_reg == tail_reg);
    assign full_now  = (tail_adv == head_reg);
    assign walk_done = (walk_reg == tail_reg);
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = (state_reg == cqf_pkg::BK_IDLE) && !cmd_valid;
    assign cfg_fire  = cfg_valid && cfg_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cqf_pkg::BK_IDLE:
            begin
                if (!cfg_fire && cmd_valid && !empty_now)
                begin
                    if (cmd.op == cqf_pkg::OP_POP)
                        state_next = cqf_pkg::BK_POP_WAIT;
                    else if (cmd.op == cqf_pkg::OP_SHOW)
                        state_next = cqf_pkg::BK_SHOW;
                end
            end
            cqf_pkg::BK_POP_WAIT:
            begin
                if (out_free)
                    state_next = cqf_pkg::BK_IDLE;
            end
            cqf_pkg::BK_SHOW:
            begin
                if (out_free && walk_done)
                    state_next = cqf_pkg::BK_IDLE;
            end
            default: state_next = cqf_pkg::BK_IDLE;
        endcase
    end

    // datapath controls and result load
    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        walk_next = walk_reg;
        size_next = size_reg;
        wr_en     = 1'b0;
        wr_addr   = tail_adv;
        rd_en     = 1'b0;
        rd_addr   = head_adv;
        cmd_take  = 1'b0;
        load      = 1'b0;
        ld_status = cqf_pkg::ST_OK;
        ld_value  = '0;
        ld_last   = 1'b1;
        case (state_reg)
            cqf_pkg::BK_IDLE:
            begin
                if (cfg_fire)
                begin
                    size_next = queue_size;
                    head_next = '0;
                    tail_next = '0;
                end
                else if (cmd_valid)
                begin
                    case (cmd.op)
                        cqf_pkg::OP_PUSH:
                        begin
                            if (out_free)
                            begin
                                cmd_take = 1'b1;
                                load     = 1'b1;
                                if (full_now)
                                    ld_status = cqf_pkg::ST_FULL;
                                else
                                begin
                                    wr_en     = 1'b1;
                                    tail_next = tail_adv;
                                end
                            end
                        end
                        cqf_pkg::OP_POP, cqf_pkg::OP_SHOW:
                        begin
                            if (empty_now)
                            begin
                                if (out_free)
                                begin
                                    cmd_take  = 1'b1;
                                    load      = 1'b1;
                                    ld_status = cqf_pkg::ST_EMPTY;
                                end
                            end
                            else
                            begin
                                cmd_take = 1'b1;
                                rd_en    = 1'b1;
                                rd_addr  = head_adv;
                                if (cmd.op == cqf_pkg::OP_POP)
                                    head_next = head_adv;
                                else
                                    walk_next = head_adv;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            cqf_pkg::BK_POP_WAIT:
            begin
                if (out_free)
                begin
                    load     = 1'b1;
                    ld_value = rd_data;
                end
            end
            cqf_pkg::BK_SHOW:
            begin
                if (out_free)
                begin
                    load     = 1'b1;
                    ld_value = rd_data;
                    ld_last  = walk_done;
                    if (!walk_done)
                    begin
                        walk_next = walk_adv;
                        rd_en     = 1'b1;
                        rd_addr   = walk_adv;
                    end
                end
            end
            default: ;
        endcase
    end

    assign empty_after    = (head_next == tail_next);
    assign full_after     = (cqf_pkg::next_idx(tail_next, len) == head_next);
    assign out_valid_next = load || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cqf_pkg::BK_IDLE;
            size_reg      <= cqf_pkg::SIZE_W'(cqf_pkg::MAX_SLOTS);
            head_reg      <= '0;
            tail_reg      <= '0;
            walk_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            size_reg      <= size_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            walk_reg      <= walk_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg    <= ld_status;
            value_reg     <= ld_value;
            is_last_reg   <= ld_last;
            now_empty_reg <= empty_after;
            now_full_reg  <= full_after;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign value     = value_reg;
    assign is_last   = is_last_reg;
    assign now_empty = now_empty_reg;
    assign now_full  = now_full_reg;

    // indices stay inside the ring in use
    a_idx_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        (int'(head_reg) < int'(len)) && (int'(tail_reg) < int'(len)))
        else $error("ring index beyond slot count");

    // a slot is never written over the oldest word
    a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !full_now)
        else $error("write into full ring");

    // no write while a pop or show read is in flight
    a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != cqf_pkg::BK_IDLE) |-> !wr_en)
        else $error("write during read sequence");

    // an empty report always carries the empty flag
    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == cqf_pkg::ST_EMPTY) |-> now_empty_reg)
        else $error("empty status without empty flag");

    // a size write empties the ring
    a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_fire |=> (head_reg == '0) && (tail_reg == '0))
        else $error("size write left ring non-empty");

endmodule

>>> rtl/core/circular_queue_fifo.sv
// top level of the circular queue fifo: ring buffer of signed 32-bit words
// depends on cqf_pkg, cqf_front, cqf_back (which holds cqf_ram)
//
// input channel in_valid/in_stall: func (0 push, 1 pop, 2 show) and
//   push_value; an item is taken with in_valid high and in_stall low;
//   func code 3 is taken and dropped with no result
// output channel out_valid/out_stall: status, value, is_last, now_empty,
//   now_full; a result is taken with out_valid high and out_stall low
// size port cfg_valid/cfg_ready, queue_size: slot count clamped to 2..16,
//   also empties the ring; ready only when no item is queued or in progress
// flow: items pass a two-entry command queue, then the back end
//   push: handled in the back end idle state, which loads the result register,
//   so pushes run at one per cycle while out_stall is low
//   pop: slot ram read in the idle state, then the result load in the pop wait state
//   show: one registered ram read per word, one result per word
// reset clears the indices (ring empty), sets the size to 16, drops any
//   pending result and queued command; slot contents are left as they are
// a stalled result holds; the back end waits on it and the command queue
//   takes items until both entries are full, then raises in_stall
module circular_queue_fifo (
    input  logic                               clk,
    input  logic                               rst_n,
    // item channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [cqf_pkg::FUNC_W-1:0]         func,
    input  logic signed [cqf_pkg::WORD_W-1:0]  push_value,
    // result channel
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [cqf_pkg::STATUS_W-1:0]       status,
    output logic signed [cqf_pkg::WORD_W-1:0]  value,
    output logic                               is_last,
    output logic                               now_empty,
    output logic                               now_full,
    // size register write
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [cqf_pkg::SIZE_W-1:0]         queue_size
);

    // command hand-off between front and back
    logic          cmd_valid;
    cqf_pkg::cmd_t cmd;
    logic          cmd_take;

    // front: takes items, drops unknown codes, buffers two commands
    cqf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .push_value (push_value),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_take   (cmd_take)
    );

    // back: ring state, slot ram, show walk and result register
    cqf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_take   (cmd_take),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .queue_size (queue_size),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .value      (value),
        .is_last    (is_last),
        .now_empty  (now_empty),
        .now_full   (now_full)
    );

endmodule

>>> dv/circular_queue_fifo_test.sv
// self-checking testbench for circular_queue_fifo: directed and random items
// depends on cqf_pkg and the rtl under rtl/core; checks against a ring model
module circular_queue_fifo_test;

    // func code that the block takes and drops without a result
    localparam logic [cqf_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    // long receiver hold-off, enough to fill the command queue behind it
    localparam int HOLD_CYCLES   = 64;
    // quiet cycles before a size write, covers a full show plus the pipeline
    localparam int SETTLE_CYCLES = 24;
    // watchdog, well above the slowest correct run
    localparam int CYCLE_LIMIT   = 200000;

    // random phases: size written at the start, then this many counted items
    // extremes 31 and 0 (clamped), 1 (clamped), full size 16, beyond range 17
    localparam int NUM_PHASES = 7;
    localparam logic [cqf_pkg::SIZE_W-1:0] PHASE_SIZE [NUM_PHASES] =
        '{5'd31, 5'd0, 5'd5, 5'd16, 5'd1, 5'd17, 5'd9};
    localparam int PHASE_ITEMS [NUM_PHASES] = '{18, 8, 12, 28, 6, 10, 10};

    typedef struct {
        cqf_pkg::status_t                  status;
        logic signed [cqf_pkg::WORD_W-1:0] value;
        logic                              is_last;
        logic                              now_empty;
        logic                              now_full;
    } result_t;

    // ring model plus the list of results still owed by the block
    class ring_tracker;
        logic [cqf_pkg::SIZE_W-1:0]        size_reg;
        logic [cqf_pkg::IDX_W-1:0]         head;
        logic [cqf_pkg::IDX_W-1:0]         tail;
        logic signed [cqf_pkg::WORD_W-1:0] slots [cqf_pkg::MAX_SLOTS];
        result_t                           due [$];
        int                                errors;

        function new();
            size_reg = cqf_pkg::SIZE_W'(cqf_pkg::MAX_SLOTS);
            head     = '0;
            tail     = '0;
            errors   = 0;
        endfunction

        // a size write also empties the ring
        function void resize(input logic [cqf_pkg::SIZE_W-1:0] sz);
            size_reg = sz;
            head     = '0;
            tail     = '0;
        endfunction

        function int slot_count();
            if (size_reg < 2)
                return 2;
            if (size_reg > cqf_pkg::MAX_SLOTS)
                return cqf_pkg::MAX_SLOTS;
            return int'(size_reg);
        endfunction

        function logic [cqf_pkg::IDX_W-1:0] step_on(input logic [cqf_pkg::IDX_W-1:0] i);
            return (int'(i) + 1 >= slot_count()) ? '0 : i + 1'b1;
        endfunction

        function bit ring_empty();
            return head == tail;
        endfunction

        function bit ring_full();
            return step_on(tail) == head;
        endfunction

        function void owe(input cqf_pkg::status_t st,
                          input logic signed [cqf_pkg::WORD_W-1:0] v,
                          input bit last);
            result_t r;
            r.status    = st;
            r.value     = v;
            r.is_last   = last;
            r.now_empty = ring_empty();
            r.now_full  = ring_full();
            due.push_back(r);
        endfunction

        // one accepted item: update the ring and queue what it should produce
        function void take_item(input logic [cqf_pkg::FUNC_W-1:0] f,
                                input logic signed [cqf_pkg::WORD_W-1:0] w);
            logic [cqf_pkg::IDX_W-1:0] i;
            int                        n;
            case (f)
                cqf_pkg::FUNC_PUSH:
                    if (ring_full())
                        owe(cqf_pkg::ST_FULL, '0, 1'b1);
                    else
                    begin
                        tail        = step_on(tail);
                        slots[tail] = w;
                        owe(cqf_pkg::ST_OK, '0, 1'b1);
                    end
                cqf_pkg::FUNC_POP:
                    if (ring_empty())
                        owe(cqf_pkg::ST_EMPTY, '0, 1'b1);
                    else
                    begin
                        head = step_on(head);
                        owe(cqf_pkg::ST_OK, slots[head], 1'b1);
                    end
                cqf_pkg::FUNC_SHOW:
                    if (ring_empty())
                        owe(cqf_pkg::ST_EMPTY, '0, 1'b1);
                    else
                    begin
                        i = head;
                        n = 0;
                        do
                        begin
                            i = step_on(i);
                            owe(cqf_pkg::ST_OK, slots[i], i == tail);
                            n++;
                        end while (i != tail && n < cqf_pkg::MAX_SLOTS - 1);
                    end
                default:
                    ;
            endcase
        endfunction

        function void match_result(input logic [cqf_pkg::STATUS_W-1:0] st,
                                   input logic signed [cqf_pkg::WORD_W-1:0] v,
                                   input logic last, input logic emp, input logic full);
            result_t r;
            if (due.size() == 0)
            begin
                $error("result with nothing expected: status %0d, value %0d", st, v);
                errors++;
                return;
            end
            r = due.pop_front();
            if (st !== r.status)
            begin
                $error("status: expected %0d, got %0d", r.status, st);
                errors++;
            end
            if (v !== r.value)
            begin
                $error("value: expected %0d, got %0d", r.value, v);
                errors++;
            end
            if (last !== r.is_last)
            begin
                $error("is_last: expected %0d, got %0d", r.is_last, last);
                errors++;
            end
            if (emp !== r.now_empty)
            begin
                $error("now_empty: expected %0d, got %0d", r.now_empty, emp);
                errors++;
            end
            if (full !== r.now_full)
            begin
                $error("now_full: expected %0d, got %0d", r.now_full, full);
                errors++;
            end
        endfunction

        function int waiting();
            return due.size();
        endfunction
    endclass

    logic                                 clk = 1'b0;
    logic                                 rst_n;
    logic                                 in_valid;
    logic                                 in_stall;
    logic [cqf_pkg::FUNC_W-1:0]           func;
    logic signed [cqf_pkg::WORD_W-1:0]    push_value;
    logic                                 out_valid;
    logic                                 out_stall;
    logic [cqf_pkg::STATUS_W-1:0]         status;
    logic signed [cqf_pkg::WORD_W-1:0]    value;
    logic                                 is_last;
    logic                                 now_empty;
    logic                                 now_full;
    logic                                 cfg_valid;
    logic                                 cfg_ready;
    logic [cqf_pkg::SIZE_W-1:0]           queue_size;

    ring_tracker ring = new();

    // no random idling on either side while set
    bit steady = 1'b0;
    // long hold-offs asked by the stimulus and served by the receiver
    int holds_asked = 0;
    int holds_done  = 0;
    int cycles      = 0;

    circular_queue_fifo DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .push_value (push_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .value      (value),
        .is_last    (is_last),
        .now_empty  (now_empty),
        .now_full   (now_full),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .queue_size (queue_size)
    );

    // period of 4
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // both handshakes sampled at the rising edge, before the block updates
    // results are checked before the item of the same edge is noted; no item
    // can produce a result in the edge that accepts it
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                ring.match_result(status, value, is_last, now_empty, now_full);
            if (in_valid && !in_stall)
                ring.take_item(func, push_value);
        end
    end

    // receiver: random stall, or a long hold-off when one is asked for
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (holds_asked > holds_done)
            begin
                holds_done++;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else
                out_stall <= !steady && ($urandom_range(99) < 18);
        end
    end

    // present one item from a falling edge and hold it until taken
    // valid is lowered only for a gap, so back-to-back items keep it high
    task automatic offer(input logic [cqf_pkg::FUNC_W-1:0] f,
                         input logic signed [cqf_pkg::WORD_W-1:0] w);
        while (!steady && $urandom_range(99) < 18)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        func       <= f;
        push_value <= w;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    // stop sending and wait until every owed result has come back
    task automatic drain();
        in_valid <= 1'b0;
        while (ring.waiting() != 0)
            @(negedge clk);
    endtask

    // size write only with the block idle; a dropped item leaves no result,
    // so allow a quiet stretch before the write
    task automatic write_size(input logic [cqf_pkg::SIZE_W-1:0] sz);
        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_valid  <= 1'b1;
        queue_size <= sz;
        do @(posedge clk); while (!cfg_ready);
        ring.resize(sz);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // pushes dominate while filling, pops afterwards; a few shows and dropped codes
    function automatic logic [cqf_pkg::FUNC_W-1:0] pick_func(input bit filling);
        int r;
        r = $urandom_range(99);
        if (r < 4)
            return FUNC_UNUSED;
        if (r < 14)
            return cqf_pkg::FUNC_SHOW;
        if (r < (filling ? 88 : 40))
            return cqf_pkg::FUNC_PUSH;
        return cqf_pkg::FUNC_POP;
    endfunction

    initial
    begin
        int                         kept;
        bit                         paused;
        logic [cqf_pkg::FUNC_W-1:0] f;

        in_valid   <= 1'b0;
        func       <= cqf_pkg::FUNC_PUSH;
        push_value <= '0;
        cfg_valid  <= 1'b0;
        queue_size <= '0;
        rst_n      <= 1'b0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset size: empty cases, word extremes, dropped code, show and pops
        offer(cqf_pkg::FUNC_POP, '0);
        offer(cqf_pkg::FUNC_SHOW, '0);
        offer(cqf_pkg::FUNC_PUSH, 32'sh80000000);
        offer(cqf_pkg::FUNC_PUSH, 32'sh7fffffff);
        offer(FUNC_UNUSED, -1);
        offer(cqf_pkg::FUNC_SHOW, '0);
        offer(cqf_pkg::FUNC_POP, '0);
        offer(cqf_pkg::FUNC_PUSH, '0);
        offer(cqf_pkg::FUNC_PUSH, -1);
        offer(cqf_pkg::FUNC_POP, '0);
        offer(cqf_pkg::FUNC_POP, '0);

        // two slots: the write must empty the ring still holding a word,
        // then one word fills it and the next push is refused
        write_size(5'd2);
        offer(cqf_pkg::FUNC_PUSH, 32'sh55555555);
        offer(cqf_pkg::FUNC_PUSH, 32'shaaaaaaaa);
        offer(cqf_pkg::FUNC_SHOW, '0);
        offer(cqf_pkg::FUNC_POP, '0);
        offer(cqf_pkg::FUNC_SHOW, '0);
        offer(cqf_pkg::FUNC_POP, '0);

        // random phases over the size settings
        paused = 1'b0;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_size(PHASE_SIZE[p]);
            // the last phases run with no idling at all
            steady = (p >= NUM_PHASES - 2);
            // receiver holds off while the ring is being filled at full size
            if (PHASE_SIZE[p] == 5'd16)
                holds_asked++;
            kept = 0;
            while (kept < PHASE_ITEMS[p])
            begin
                // in the first phase the sender pauses once mid-phase until everything is back
                if (p == 0 && kept == PHASE_ITEMS[p] / 2 && !paused)
                begin
                    drain();
                    paused = 1'b1;
                end
                f = pick_func(kept < PHASE_ITEMS[p] * 2 / 3);
                if (f != FUNC_UNUSED)
                    kept++;
                offer(f, $urandom);
            end
        end
        steady = 1'b0;

        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (ring.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
